// ----- rtl/scf_pkg.sv -----
`timescale 1ns / 1ps

package scf_pkg;

   localparam logic [7:0]  StartByte      = 8'hA5;
   localparam logic [15:0] CrcPoly        = 16'h1021;
   localparam logic [1:0]  MaxWords       = 2'd3;
   localparam int          StatusBytePos  = 3;

   // Reply status codes.
   localparam logic [2:0] StatusComplete   = 3'd0;
   localparam logic [2:0] StatusIncomplete = 3'd1;
   localparam logic [2:0] StatusInvalid    = 3'd2;
   localparam logic [2:0] StatusNoWrite    = 3'd3;
   localparam logic [2:0] StatusCrcError   = 3'd4;
   localparam logic [2:0] StatusCommError  = 3'd5;
   localparam logic [2:0] StatusUnknown    = 3'd6;

   // Raw status byte values found in reply byte 3.
   localparam logic [7:0] RawComplete   = 8'h01;
   localparam logic [7:0] RawIncomplete = 8'h02;
   localparam logic [7:0] RawInvalid    = 8'h04;
   localparam logic [7:0] RawNoWrite    = 8'h06;
   localparam logic [7:0] RawCrcError   = 8'h08;

   localparam logic OpCommand = 1'b0;
   localparam logic OpReply   = 1'b1;

   localparam logic KindTxByte = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef logic [3:0] pc_type;

   typedef enum logic [3:0] {
      SRC_START,
      SRC_NODE,
      SRC_CMD,
      SRC_INDEX,
      SRC_OFFSET,
      SRC_WORDS,
      SRC_CRC_HI,
      SRC_CRC_LO,
      SRC_DATA
   } byte_src_type;

   typedef enum logic [1:0] {
      CRC_HOLD,
      CRC_UPDATE,
      CRC_CLEAR
   } crc_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_END_IF_NO_DATA,
      JMP_LOOP_DATA,
      JMP_END
   } jump_type;

   typedef struct packed {
      byte_src_type src;
      crc_op_type   crc_op;
      jump_type     jump;
   } ucode_type;

   // Strobe and control word handed from the sequencer to the datapath.
   typedef struct packed {
      logic         step;
      byte_src_type src;
      crc_op_type   crc_op;
   } dp_ctrl_type;

   // Conditions the datapath reports back for the conditional jumps.
   typedef struct packed {
      logic no_data;
      logic data_done;
   } dp_flags_type;

   // Frame program: one step per transmitted byte.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         4'd0:    w = '{SRC_START,  CRC_UPDATE, JMP_NEXT};
         4'd1:    w = '{SRC_NODE,   CRC_UPDATE, JMP_NEXT};
         4'd2:    w = '{SRC_CMD,    CRC_UPDATE, JMP_NEXT};
         4'd3:    w = '{SRC_INDEX,  CRC_UPDATE, JMP_NEXT};
         4'd4:    w = '{SRC_OFFSET, CRC_UPDATE, JMP_NEXT};
         4'd5:    w = '{SRC_WORDS,  CRC_UPDATE, JMP_NEXT};
         4'd6:    w = '{SRC_CRC_HI, CRC_HOLD,   JMP_NEXT};
         4'd7:    w = '{SRC_CRC_LO, CRC_CLEAR,  JMP_END_IF_NO_DATA};
         4'd8:    w = '{SRC_DATA,   CRC_UPDATE, JMP_LOOP_DATA};
         4'd9:    w = '{SRC_CRC_HI, CRC_HOLD,   JMP_NEXT};
         4'd10:   w = '{SRC_CRC_LO, CRC_HOLD,   JMP_END};
         default: w = '{SRC_CRC_LO, CRC_HOLD,   JMP_END};
      endcase
      return w;
   endfunction

   // One byte of CRC-16 in the direct form; with a zero start value this
   // equals the augmented form taken over the section and two zero bytes.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data_in);
      logic [15:0] c;
      c = crc_in ^ {data_in, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/scf_if.sv -----
`timescale 1ns / 1ps

interface scf_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  command_code;
   logic [7:0]  reg_index;
   logic [7:0]  reg_offset;
   logic [1:0]  word_count;
   logic [47:0] data_value;
   logic [7:0]  rx_byte;

   modport source (
      output valid, op, command_code, reg_index, reg_offset, word_count,
             data_value, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, op, command_code, reg_index, reg_offset, word_count,
             data_value, rx_byte,
      output ready
   );
endinterface

interface scf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       last;
   logic [2:0] status;

   modport source (
      output valid, kind, tx_byte, last, status,
      input  ready
   );
   modport sink (
      input  valid, kind, tx_byte, last, status,
      output ready
   );
endinterface

// ----- rtl/servo_serial_command_framer.sv -----
`timescale 1ns / 1ps

// Builds servo-drive command frames and decodes drive replies. A command
// request is taken and then sent one frame byte per cycle by a small
// microcoded sequencer stepping a frame program: 8 bytes for a header
// frame, 10 + 2 * words bytes with data; a stalled result holds the
// program step. The CRC-16 (0x1021) is updated one whole byte per program
// step. The last byte of a reply loads one status result, which is
// offered from the next cycle. The node address register is written
// by csr_write_enable and should be changed only while the block is idle.
module servo_serial_command_framer
   import scf_pkg::*;
#(
   parameter int REPLY_LENGTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   scf_req_if.sink     req_chan,
   scf_rsp_if.source   rsp_chan
);

   logic [7:0]   node_address_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_kind_ff, rsp_kind_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;
   logic         rsp_last_ff, rsp_last_in;
   logic [2:0]   rsp_status_ff, rsp_status_in;
   logic         out_free;
   logic         req_take, cmd_take, reply_take;
   logic         seq_busy, seq_last;
   dp_ctrl_type  dp_ctrl;
   dp_flags_type dp_flags;
   logic [7:0]   frame_byte;
   logic         reply_done;
   logic [2:0]   reply_status;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !seq_busy && out_free;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign cmd_take       = req_take && (req_chan.op == OpCommand);
   assign reply_take     = req_take && (req_chan.op == OpReply);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= 8'd1;
      end else if (csr_write_enable) begin
         node_address_ff <= csr_write_data;
      end
   end

   scf_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd_take),
      .advance (out_free),
      .flags   (dp_flags),
      .ctrl    (dp_ctrl),
      .busy    (seq_busy),
      .last    (seq_last)
   );

   scf_frame_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd_take),
      .node_address (node_address_ff),
      .command_code (req_chan.command_code),
      .reg_index    (req_chan.reg_index),
      .reg_offset   (req_chan.reg_offset),
      .word_count   (req_chan.word_count),
      .data_value   (req_chan.data_value),
      .ctrl         (dp_ctrl),
      .flags        (dp_flags),
      .tx_byte      (frame_byte)
   );

   scf_reply_decoder #(
      .REPLY_LENGTH (REPLY_LENGTH)
   ) u_reply (
      .clock   (clock),
      .reset   (reset),
      .take    (reply_take),
      .rx_byte (req_chan.rx_byte),
      .done    (reply_done),
      .status  (reply_status)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (dp_ctrl.step) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KindTxByte;
         rsp_byte_in   = frame_byte;
         rsp_last_in   = seq_last;
         rsp_status_in = StatusComplete;
      end else if (reply_done) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KindStatus;
         rsp_byte_in   = 8'h00;
         rsp_last_in   = 1'b1;
         rsp_status_in = reply_status;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.kind    = rsp_kind_ff;
   assign rsp_chan.tx_byte = rsp_byte_ff;
   assign rsp_chan.last    = rsp_last_ff;
   assign rsp_chan.status  = rsp_status_ff;

   // A frame byte is only written into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      dp_ctrl.step |-> out_free)
      else $error("frame byte would overwrite a pending result");

   // Frame bytes and reply status never compete for the output register.
   assert property (@(posedge clock) disable iff (reset)
      !(seq_busy && reply_done))
      else $error("reply completed while a frame was being sent");

   // When the program finishes, the closing byte of the frame is on offer.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(seq_busy) && !$past(reset)) |->
         (rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == KindTxByte)))
      else $error("frame ended without a closing byte");

endmodule

// ----- rtl/scf_sequencer.sv -----
`timescale 1ns / 1ps

module scf_sequencer
   import scf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         advance,
   input  dp_flags_type flags,
   output dp_ctrl_type  ctrl,
   output logic         busy,
   output logic         last
);

   logic      busy_ff, busy_in;
   pc_type    pc_ff, pc_in;
   ucode_type uword;
   logic      step;

   assign uword = ucode_rom(pc_ff);
   assign step  = busy_ff && advance;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      last    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (step) begin
         case (uword.jump)
            JMP_NEXT: begin
               pc_in = pc_ff + 1'b1;
            end
            JMP_END_IF_NO_DATA: begin
               if (flags.no_data) begin
                  busy_in = 1'b0;
                  last    = 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            JMP_LOOP_DATA: begin
               if (flags.data_done) begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            JMP_END: begin
               busy_in = 1'b0;
               last    = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
               last    = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.step   = step;
   assign ctrl.src    = uword.src;
   assign ctrl.crc_op = uword.crc_op;
   assign busy        = busy_ff;

endmodule

// ----- rtl/scf_frame_datapath.sv -----
`timescale 1ns / 1ps

module scf_frame_datapath
   import scf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [7:0]   node_address,
   input  logic [7:0]   command_code,
   input  logic [7:0]   reg_index,
   input  logic [7:0]   reg_offset,
   input  logic [1:0]   word_count,
   input  logic [47:0]  data_value,
   input  dp_ctrl_type  ctrl,
   output dp_flags_type flags,
   output logic [7:0]   tx_byte
);

   logic [7:0]  cmd_ff, index_ff, offset_ff;
   logic [1:0]  words_ff;
   logic [47:0] data_ff;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  data_idx_ff, data_idx_in;
   logic [1:0]  words_sat;
   logic [2:0]  byte_total;

   assign words_sat  = (word_count > MaxWords) ? MaxWords : word_count;
   assign byte_total = {words_ff, 1'b0};

   always_comb begin
      case (ctrl.src)
         SRC_START:  tx_byte = StartByte;
         SRC_NODE:   tx_byte = node_address;
         SRC_CMD:    tx_byte = cmd_ff;
         SRC_INDEX:  tx_byte = index_ff;
         SRC_OFFSET: tx_byte = offset_ff;
         SRC_WORDS:  tx_byte = {6'd0, words_ff};
         SRC_CRC_HI: tx_byte = crc_ff[15:8];
         SRC_CRC_LO: tx_byte = crc_ff[7:0];
         SRC_DATA:   tx_byte = data_ff[{data_idx_ff, 3'b000} +: 8];
         default:    tx_byte = 8'h00;
      endcase
   end

   always_comb begin
      crc_in      = crc_ff;
      data_idx_in = data_idx_ff;
      if (start) begin
         crc_in      = '0;
         data_idx_in = '0;
      end else if (ctrl.step) begin
         case (ctrl.crc_op)
            CRC_UPDATE: crc_in = crc16_byte(crc_ff, tx_byte);
            CRC_CLEAR:  crc_in = '0;
            default:    crc_in = crc_ff;
         endcase
         if (ctrl.src == SRC_DATA) begin
            data_idx_in = data_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= '0;
         data_idx_ff <= '0;
      end else begin
         crc_ff      <= crc_in;
         data_idx_ff <= data_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff    <= command_code;
         index_ff  <= reg_index;
         offset_ff <= reg_offset;
         words_ff  <= words_sat;
         data_ff   <= data_value;
      end
   end

   assign flags.no_data   = (words_ff == 2'd0);
   assign flags.data_done = ((data_idx_ff + 3'd1) == byte_total);

endmodule

// ----- rtl/scf_reply_decoder.sv -----
`timescale 1ns / 1ps

module scf_reply_decoder
   import scf_pkg::*;
#(
   parameter int REPLY_LENGTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   output logic       done,
   output logic [2:0] status
);

   localparam int CountWidth = $clog2(REPLY_LENGTH);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  start_ok_ff, start_ok_in;
   logic [7:0]            status_byte_ff, status_byte_in;
   logic [CountWidth:0]   count_next;

   assign count_next = {1'b0, count_ff} + 1'b1;

   always_comb begin
      count_in       = count_ff;
      start_ok_in    = start_ok_ff;
      status_byte_in = status_byte_ff;
      done           = 1'b0;
      if (take) begin
         if (count_ff == '0) begin
            start_ok_in = (rx_byte == StartByte);
         end
         if (count_ff == CountWidth'(StatusBytePos)) begin
            status_byte_in = rx_byte;
         end
         if (count_next == (CountWidth + 1)'(REPLY_LENGTH)) begin
            count_in = '0;
            done     = 1'b1;
         end else begin
            count_in = count_next[CountWidth-1:0];
         end
      end
   end

   // Decoded from the updated values so that the closing byte counts too.
   always_comb begin
      if (!start_ok_in) begin
         status = StatusCommError;
      end else begin
         case (status_byte_in)
            RawComplete:   status = StatusComplete;
            RawIncomplete: status = StatusIncomplete;
            RawInvalid:    status = StatusInvalid;
            RawNoWrite:    status = StatusNoWrite;
            RawCrcError:   status = StatusCrcError;
            default:       status = StatusUnknown;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         start_ok_ff    <= 1'b0;
         status_byte_ff <= '0;
      end else begin
         count_ff       <= count_in;
         start_ok_ff    <= start_ok_in;
         status_byte_ff <= status_byte_in;
      end
   end

endmodule
